@@ design/hough_line_vote_accumulator_assert.svh @@
// ----------------------------------------------------------------------------
// Hough line vote accumulator assertion macros
// Implication checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HOUGH_LINE_VOTE_ACCUMULATOR_ASSERT_SVH
`define HOUGH_LINE_VOTE_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define HLVA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HLVA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/hlva_pkg.sv @@
// ----------------------------------------------------------------------------
// hlva_pkg
// Types, constants and the Q1.14 sine/cosine table for the vote accumulator.
// ----------------------------------------------------------------------------
package hlva_pkg;

    localparam int IMG_SIZE_DEF    = 512;
    localparam int R_ROWS_DEF      = 1024;
    localparam int THETA_STEPS_DEF = 360;
    localparam int ACC_WIDTH_DEF   = 32;

    localparam int OP_W     = 2;
    localparam int COORD_W  = 9;
    localparam int STR_W    = 16;
    localparam int CELL_R_W = 10;
    localparam int ANGLE_W  = 9;
    localparam int VALUE_W  = 32;
    localparam int TRIG_W   = 16;
    localparam int PROD_W   = COORD_W + 1 + TRIG_W;
    localparam int FRAC_W   = 14;
    localparam int DIST_W   = 12;

    typedef enum logic [OP_W-1:0] {
        OP_VOTE     = 2'd0,
        OP_READ     = 2'd1,
        OP_READ_CLR = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_RANGE,
        ST_RD0,
        ST_WR0,
        ST_RD1,
        ST_WR1,
        ST_NEXT,
        ST_RDA,
        ST_RDB
    } state_t;

    // sin(d) in Q14 for d = 0..90
    function automatic logic [14:0] quarter_sine(input logic [6:0] d);
        logic [14:0] v;
        case (d)
            7'd0:  v = 15'd0;     7'd1:  v = 15'd286;   7'd2:  v = 15'd572;
            7'd3:  v = 15'd857;   7'd4:  v = 15'd1143;  7'd5:  v = 15'd1428;
            7'd6:  v = 15'd1713;  7'd7:  v = 15'd1997;  7'd8:  v = 15'd2280;
            7'd9:  v = 15'd2563;  7'd10: v = 15'd2845;  7'd11: v = 15'd3126;
            7'd12: v = 15'd3406;  7'd13: v = 15'd3686;  7'd14: v = 15'd3964;
            7'd15: v = 15'd4240;  7'd16: v = 15'd4516;  7'd17: v = 15'd4790;
            7'd18: v = 15'd5063;  7'd19: v = 15'd5334;  7'd20: v = 15'd5604;
            7'd21: v = 15'd5871;  7'd22: v = 15'd6138;  7'd23: v = 15'd6402;
            7'd24: v = 15'd6664;  7'd25: v = 15'd6924;  7'd26: v = 15'd7182;
            7'd27: v = 15'd7438;  7'd28: v = 15'd7692;  7'd29: v = 15'd7943;
            7'd30: v = 15'd8192;  7'd31: v = 15'd8438;  7'd32: v = 15'd8682;
            7'd33: v = 15'd8923;  7'd34: v = 15'd9162;  7'd35: v = 15'd9397;
            7'd36: v = 15'd9630;  7'd37: v = 15'd9860;  7'd38: v = 15'd10087;
            7'd39: v = 15'd10311; 7'd40: v = 15'd10531; 7'd41: v = 15'd10749;
            7'd42: v = 15'd10963; 7'd43: v = 15'd11174; 7'd44: v = 15'd11381;
            7'd45: v = 15'd11585; 7'd46: v = 15'd11786; 7'd47: v = 15'd11982;
            7'd48: v = 15'd12176; 7'd49: v = 15'd12365; 7'd50: v = 15'd12551;
            7'd51: v = 15'd12733; 7'd52: v = 15'd12911; 7'd53: v = 15'd13085;
            7'd54: v = 15'd13255; 7'd55: v = 15'd13421; 7'd56: v = 15'd13583;
            7'd57: v = 15'd13741; 7'd58: v = 15'd13894; 7'd59: v = 15'd14044;
            7'd60: v = 15'd14189; 7'd61: v = 15'd14330; 7'd62: v = 15'd14466;
            7'd63: v = 15'd14598; 7'd64: v = 15'd14726; 7'd65: v = 15'd14849;
            7'd66: v = 15'd14968; 7'd67: v = 15'd15082; 7'd68: v = 15'd15191;
            7'd69: v = 15'd15296; 7'd70: v = 15'd15396; 7'd71: v = 15'd15491;
            7'd72: v = 15'd15582; 7'd73: v = 15'd15668; 7'd74: v = 15'd15749;
            7'd75: v = 15'd15826; 7'd76: v = 15'd15897; 7'd77: v = 15'd15964;
            7'd78: v = 15'd16026; 7'd79: v = 15'd16083; 7'd80: v = 15'd16135;
            7'd81: v = 15'd16182; 7'd82: v = 15'd16225; 7'd83: v = 15'd16262;
            7'd84: v = 15'd16294; 7'd85: v = 15'd16322; 7'd86: v = 15'd16344;
            7'd87: v = 15'd16362; 7'd88: v = 15'd16374; 7'd89: v = 15'd16382;
            7'd90: v = 15'd16384;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // d in 0..359
    function automatic logic signed [TRIG_W-1:0] sin_q14(input logic [ANGLE_W-1:0] d);
        logic [ANGLE_W-1:0] k;
        logic               neg;
        logic [14:0]        q;
        if (d <= 9'd90) begin
            k = d;           neg = 1'b0;
        end else if (d <= 9'd180) begin
            k = 9'd180 - d;  neg = 1'b0;
        end else if (d <= 9'd270) begin
            k = d - 9'd180;  neg = 1'b1;
        end else begin
            k = 9'd360 - d;  neg = 1'b1;
        end
        q = quarter_sine(k[6:0]);
        return neg ? -signed'({1'b0, q}) : signed'({1'b0, q});
    endfunction

    function automatic logic signed [TRIG_W-1:0] cos_q14(input logic [ANGLE_W-1:0] d);
        logic [ANGLE_W:0] e;
        e = {1'b0, d} + 10'd90;
        if (e >= 10'd360)
            e = e - 10'd360;
        return sin_q14(e[ANGLE_W-1:0]);
    endfunction

endpackage

@@ design/hough_line_vote_accumulator.sv @@
// ----------------------------------------------------------------------------
// hough_line_vote_accumulator
// Hough line accumulator over R_ROWS x THETA_STEPS cells in one memory, with
// line votes, cell reads and read-and-clear.
// ----------------------------------------------------------------------------
//  channel | signals                                            | transfer
//  --------+----------------------------------------------------+-----------------
//  command | start, busy, op, pixel_x, pixel_y, strength,       | start && !busy
//          | cell_r, cell_angle                                 |
//  result  | done, cell_value, is_read_reply, saturated         | done (1 cycle)
//
//  After reset a clearing pass zeroes the memory with busy high. A vote holds
//  busy while it steps through all angles, plus one read-modify-write pass per
//  distance cell row crossed (one read-modify-write port, two cells per row).
//  A read holds busy through ST_RDA and ST_RDB. The result comes in the cycle
//  in which busy drops; out-of-range and OP_NONE items answer the cycle after
//  the transfer. The result side cannot stall; busy is low in the result cycle.
// ----------------------------------------------------------------------------
`include "hough_line_vote_accumulator_assert.svh"

module hough_line_vote_accumulator #(
    parameter int IMG_SIZE    = hlva_pkg::IMG_SIZE_DEF,
    parameter int R_ROWS      = hlva_pkg::R_ROWS_DEF,
    parameter int THETA_STEPS = hlva_pkg::THETA_STEPS_DEF,
    parameter int ACC_WIDTH   = hlva_pkg::ACC_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [hlva_pkg::OP_W-1:0]           op,
    input  logic [hlva_pkg::COORD_W-1:0]        pixel_x,
    input  logic [hlva_pkg::COORD_W-1:0]        pixel_y,
    input  logic signed [hlva_pkg::STR_W-1:0]   strength,
    input  logic [hlva_pkg::CELL_R_W-1:0]       cell_r,
    input  logic [hlva_pkg::ANGLE_W-1:0]        cell_angle,
    output logic                                done,
    output logic signed [hlva_pkg::VALUE_W-1:0] cell_value,
    output logic                                is_read_reply,
    output logic                                saturated
);
    import hlva_pkg::*;

    localparam int DEPTH = R_ROWS * THETA_STEPS;
    localparam int AW    = $clog2(DEPTH);
    localparam int JW    = $clog2(R_ROWS + 1);
    localparam int EW    = (ACC_WIDTH > VALUE_W) ? ACC_WIDTH : VALUE_W;
    localparam logic signed [EW-1:0] V_MAX = EW'(signed'(32'h7fff_ffff));
    localparam logic signed [EW-1:0] V_MIN = EW'(signed'(32'h8000_0000));
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic [ANGLE_W-1:0] LAST_ANG = ANGLE_W'(THETA_STEPS - 1);

    logic signed [ACC_WIDTH-1:0] mem [DEPTH];

    state_t                      state_reg, state_next;
    logic [COORD_W-1:0]          x_reg, y_reg;
    logic signed [STR_W-1:0]     str_reg;
    logic                        clr_reg;
    logic [ANGLE_W-1:0]          ang_reg;
    logic                        first_reg;
    logic signed [PROD_W-1:0]    px_reg, py_reg;
    logic signed [DIST_W-1:0]    rprev_reg, rcur_reg;
    logic [JW-1:0]               j_reg, jend_reg;
    logic [AW-1:0]               addr_reg, clr_addr_reg;
    logic                        sat_reg;
    logic signed [ACC_WIDTH-1:0] rdata_reg;
    logic                        done_reg, isread_reg, satout_reg;
    logic signed [VALUE_W-1:0]   value_reg;

    logic                        done_next, isread_next, satout_next;
    logic signed [VALUE_W-1:0]   value_next;
    logic                        mem_we, mem_re;
    logic [AW-1:0]               mem_waddr, mem_raddr;
    logic signed [ACC_WIDTH-1:0] mem_wdata;

    logic                        pix_ok, cell_ok;
    logic signed [PROD_W:0]      dsum, dneg, dq;
    logic signed [DIST_W-1:0]    dist_val;
    logic signed [DIST_W-1:0]    rmin, rmax;
    int                          lo_i, hi_i;
    logic                        range_hit;
    logic signed [ACC_WIDTH:0]   add_full;
    logic                        add_ovf;
    logic signed [ACC_WIDTH-1:0] add_sat;
    logic signed [EW-1:0]        rd_ext;
    logic signed [VALUE_W-1:0]   rd_clamp;

    assign pix_ok  = (32'(pixel_x) < IMG_SIZE) && (32'(pixel_y) < IMG_SIZE);
    assign cell_ok = (32'(cell_r) < R_ROWS) && (32'(cell_angle) < THETA_STEPS);

    // truncate toward zero
    always_comb
    begin
        dsum     = (PROD_W+1)'(px_reg) + (PROD_W+1)'(py_reg);
        dneg     = -dsum;
        dq       = dsum[PROD_W] ? -(dneg >>> FRAC_W) : (dsum >>> FRAC_W);
        dist_val = DIST_W'(dq);
    end

    always_comb
    begin
        rmin = (rprev_reg < rcur_reg) ? rprev_reg : rcur_reg;
        rmax = (rprev_reg < rcur_reg) ? rcur_reg : rprev_reg;
        lo_i = (rmin < 0) ? 0 : int'(rmin);
        if (rmax < 0)
            hi_i = 0;
        else if (int'(rmax) > R_ROWS)
            hi_i = R_ROWS;
        else
            hi_i = int'(rmax);
        range_hit = lo_i < hi_i;
    end

    always_comb
    begin
        add_full = (ACC_WIDTH+1)'(rdata_reg) + (ACC_WIDTH+1)'(str_reg);
        add_ovf  = add_full[ACC_WIDTH] != add_full[ACC_WIDTH-1];
        if (!add_ovf)
            add_sat = add_full[ACC_WIDTH-1:0];
        else if (add_full[ACC_WIDTH])
            add_sat = ACC_MIN;
        else
            add_sat = ACC_MAX;
    end

    always_comb
    begin
        rd_ext = EW'(rdata_reg);
        if (rd_ext > V_MAX)
            rd_clamp = VALUE_W'(V_MAX);
        else if (rd_ext < V_MIN)
            rd_clamp = VALUE_W'(V_MIN);
        else
            rd_clamp = VALUE_W'(rd_ext);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_addr_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (start)
                begin
                    if (op == OP_VOTE && pix_ok)
                        state_next = ST_MUL;
                    else if ((op == OP_READ || op == OP_READ_CLR) && cell_ok)
                        state_next = ST_RDA;
                end
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = first_reg ? ST_MUL : ST_RANGE;
            ST_RANGE: state_next = range_hit ? ST_RD0 : ST_NEXT;
            ST_RD0:   state_next = ST_WR0;
            ST_WR0:   state_next = ST_RD1;
            ST_RD1:   state_next = ST_WR1;
            ST_WR1:   state_next = ((j_reg + 1'b1) < jend_reg) ? ST_RD0 : ST_NEXT;
            ST_NEXT:  state_next = (ang_reg == LAST_ANG) ? ST_IDLE : ST_MUL;
            ST_RDA:   state_next = ST_RDB;
            ST_RDB:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs: memory controls and result
    always_comb
    begin
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = addr_reg;
        mem_raddr   = addr_reg;
        mem_wdata   = add_sat;
        done_next   = 1'b0;
        value_next  = '0;
        isread_next = 1'b0;
        satout_next = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
                if (start)
                begin
                    if (op == OP_READ || op == OP_READ_CLR)
                    begin
                        done_next   = !cell_ok;
                        isread_next = 1'b1;
                    end
                    else if (op == OP_VOTE)
                        done_next = !pix_ok;
                    else
                        done_next = 1'b1;
                end
            ST_RD0:   mem_re = 1'b1;
            ST_WR0:   mem_we = 1'b1;
            ST_RD1:
            begin
                mem_re    = 1'b1;
                mem_raddr = addr_reg + 1'b1;
            end
            ST_WR1:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg + 1'b1;
            end
            ST_NEXT:
                if (ang_reg == LAST_ANG)
                begin
                    done_next   = 1'b1;
                    satout_next = sat_reg;
                end
            ST_RDA:   mem_re = 1'b1;
            ST_RDB:
            begin
                mem_we      = clr_reg;
                mem_wdata   = '0;
                done_next   = 1'b1;
                isread_next = 1'b1;
                value_next  = rd_clamp;
            end
            default:  ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            ang_reg      <= '0;
            j_reg        <= '0;
            first_reg    <= 1'b0;
            sat_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            case (state_reg)
                ST_CLEAR:
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                ST_IDLE:
                    if (start)
                    begin
                        ang_reg   <= '0;
                        first_reg <= 1'b1;
                        sat_reg   <= 1'b0;
                    end
                ST_SUM:
                    if (first_reg)
                    begin
                        first_reg <= 1'b0;
                        ang_reg   <= ang_reg + 1'b1;
                    end
                ST_RANGE:
                    j_reg <= JW'(lo_i);
                ST_WR0:
                    if (add_ovf)
                        sat_reg <= 1'b1;
                ST_WR1:
                begin
                    if (add_ovf)
                        sat_reg <= 1'b1;
                    j_reg <= j_reg + 1'b1;
                end
                ST_NEXT:
                begin
                    j_reg   <= '0;
                    ang_reg <= (ang_reg == LAST_ANG) ? '0 : ang_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        isread_reg <= isread_next;
        satout_reg <= satout_next;
        case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    x_reg    <= pixel_x;
                    y_reg    <= pixel_y;
                    str_reg  <= strength;
                    clr_reg  <= (op == OP_READ_CLR);
                    addr_reg <= AW'(32'(cell_r) * THETA_STEPS + 32'(cell_angle));
                end
            ST_MUL:
            begin
                px_reg <= PROD_W'(signed'({1'b0, x_reg}) * cos_q14(ang_reg));
                py_reg <= PROD_W'(signed'({1'b0, y_reg}) * sin_q14(ang_reg));
            end
            ST_SUM:
                if (first_reg)
                    rprev_reg <= dist_val;
                else
                    rcur_reg <= dist_val;
            ST_RANGE:
            begin
                jend_reg <= JW'(hi_i);
                addr_reg <= AW'(lo_i * THETA_STEPS + int'(ang_reg) - 1);
            end
            ST_WR1:
                addr_reg <= addr_reg + AW'(THETA_STEPS);
            ST_NEXT:
                rprev_reg <= rcur_reg;
            default: ;
        endcase
    end

    assign busy          = state_reg != ST_IDLE;
    assign done          = done_reg;
    assign cell_value    = value_reg;
    assign is_read_reply = isread_reg;
    assign saturated     = satout_reg;

    `HLVA_ASSERT_NOW(a_done_idle, done, !busy, "result while an item is still at work")
    `HLVA_ASSERT_NXT(a_start_takes, start && !busy, busy || done, "transfer produced no work")
    `HLVA_ASSERT_NOW(a_read_no_sat, done && is_read_reply, !saturated, "read reply flagged saturated")
    `HLVA_ASSERT_NOW(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "read and write to one cell")

endmodule
